// ===== design/b32d_pkg.sv =====
// package for the base32 stream decoder: widths, verdict codes, state and result types
// and the alphabet lookup function; no dependencies
`default_nettype none

package b32d_pkg;

	localparam int unsigned CharW   = 8;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned SymW    = 5;
	localparam int unsigned ResW    = 7;
	localparam int unsigned ResCntW = 3;
	localparam int unsigned CntW    = 8;
	localparam int unsigned BufW    = ResW + SymW;
	localparam int unsigned BitsW   = 4;

	localparam logic [CharW-1:0] CharUpA   = 8'h41;
	localparam logic [CharW-1:0] CharUpZ   = 8'h5a;
	localparam logic [CharW-1:0] CharTwo   = 8'h32;
	localparam logic [CharW-1:0] CharSeven = 8'h37;
	localparam logic [SymW-1:0]  DigitBase = 5'd26;
	localparam logic [CntW-1:0]  CntMax    = 8'hff;
	localparam logic [BitsW-1:0] ByteBits  = 4'd8;
	localparam logic [BitsW-1:0] SymBits   = 4'd5;

	typedef enum logic [1:0] {
		VERDICT_CONT   = 2'd0,
		VERDICT_ACCEPT = 2'd1,
		VERDICT_REJECT = 2'd2
	} verdict_t;

	typedef struct packed {
		logic [ResW-1:0]    res_bits;
		logic [ResCntW-1:0] res_count;
		logic               failed;
		logic [CntW-1:0]    count;
	} dec_state_t;

	typedef struct packed {
		logic [ByteW-1:0] out_byte;
		logic             byte_valid;
		logic             string_done;
		verdict_t         verdict;
	} dec_result_t;

	typedef struct packed {
		logic            ok;
		logic [SymW-1:0] value;
	} sym_t;

	function automatic sym_t sym_lookup(input logic [CharW-1:0] c);
		sym_t s;
		logic [CharW-1:0] d;
		s = '0;
		d = '0;
		if (c >= CharUpA && c <= CharUpZ) begin
			d = c - CharUpA;
			s.ok = 1'b1;
			s.value = d[SymW-1:0];
		end else if (c >= CharTwo && c <= CharSeven) begin
			d = c - CharTwo;
			s.ok = 1'b1;
			s.value = DigitBase + d[SymW-1:0];
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== design/b32d_char_if.sv =====
// character channel: valid/ready handshake with one base32 character per item
// depends on b32d_pkg
`default_nettype none

interface b32d_char_if;
	import b32d_pkg::*;

	logic             valid;
	logic             ready;
	logic [CharW-1:0] char_code;
	logic             last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// ===== design/b32d_result_if.sv =====
// result channel: valid/ready handshake with one decoder result per item
// depends on b32d_pkg
`default_nettype none

interface b32d_result_if;
	import b32d_pkg::*;

	logic             valid;
	logic             ready;
	logic [ByteW-1:0] out_byte;
	logic             byte_valid;
	logic             string_done;
	logic [1:0]       verdict;

	modport source (output valid, output out_byte, output byte_valid, output string_done,
		output verdict, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input string_done,
		input verdict, output ready);
endinterface

`default_nettype wire

// ===== design/b32d_step.sv =====
// one decode step: maps a character, shifts its five bits into the residual buffer,
// releases a byte and forms the end-of-string verdict; depends on b32d_pkg
`default_nettype none

module b32d_step
	import b32d_pkg::*;
(
	input  dec_state_t        state,
	input  logic [CharW-1:0]  char_code,
	input  logic              last_char,
	input  logic [CntW-1:0]   expected_length,
	output dec_state_t        state_next,
	output dec_result_t       result
);

	sym_t             sym;
	logic [BufW-1:0]  buf_w;
	logic [BufW-1:0]  mask;
	logic [BufW-1:0]  kept;
	logic [BufW-1:0]  shifted;
	logic [BitsW-1:0] bits;
	logic [BitsW-1:0] left;
	logic             full;
	logic [CntW-1:0]  cnt;
	dec_state_t       upd;
	logic             bad;

	always_comb begin
		sym     = sym_lookup(char_code);
		buf_w   = {state.res_bits, sym.value};
		bits    = {1'b0, state.res_count} + SymBits;
		full    = bits >= ByteBits;
		left    = full ? bits - ByteBits : bits;
		shifted = buf_w >> left;
		mask    = (BufW'(1) << left) - BufW'(1);
		kept    = full ? (buf_w & mask) : buf_w;
		cnt     = (state.count != CntMax) ? state.count + CntW'(1) : state.count;

		upd = state;
		upd.count = cnt;
		if (sym.ok) begin
			upd.res_bits  = kept[ResW-1:0];
			upd.res_count = left[ResCntW-1:0];
		end else begin
			upd.failed = 1'b1;
		end

		result.byte_valid  = sym.ok && full && !state.failed;
		result.out_byte    = result.byte_valid ? shifted[ByteW-1:0] : '0;
		result.string_done = last_char;
		result.verdict     = VERDICT_CONT;

		bad = upd.failed
			|| (upd.res_count != '0 && upd.res_bits != '0)
			|| (expected_length != '0 && upd.count != expected_length);

		state_next = upd;
		if (last_char) begin
			result.verdict = bad ? VERDICT_REJECT : VERDICT_ACCEPT;
			state_next = '0;
		end
	end

endmodule

`default_nettype wire

// ===== design/base32_stream_decoder.sv =====
// Unpadded base32 stream decoder, top level.
// Depends on b32d_pkg, b32d_char_if, b32d_result_if and b32d_step.
//
// char_ch carries one character per item with last_char on the final one of a
// string. result_ch returns exactly one item per character: out_byte with
// byte_valid when the character completed a byte with no bad character earlier in
// the string, and on the last character string_done with verdict accepted or
// rejected. Bytes of a rejected string must be discarded by the receiver.
// expected_length is written through cfg_wr_en/cfg_wr_data; the user must write it only
// while idle, which the block does not enforce; zero turns the length check off.
// An accepted character goes into the input register and its result is offered from
// the result register; throughput is one item per cycle while result_ch does not stall,
// set by the input register feeding a single decode step into the result register, with
// the string state updated in that same step.
// Reset clears both stage valids, the string state and expected_length.
// When result_ch stalls the result register holds, then the input register fills,
// and char_ch.ready drops until the receiver takes the result.
`default_nettype none

module base32_stream_decoder
	import b32d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CntW-1:0]   cfg_wr_data,
	b32d_char_if.sink         char_ch,
	b32d_result_if.source     result_ch
);

	logic             valid_s1;
	logic [CharW-1:0] char_s1;
	logic             last_s1;
	logic             valid_s2;
	dec_result_t      res_s2;
	dec_state_t       state_q;
	dec_state_t       state_next;
	dec_result_t      res_next;
	logic [CntW-1:0]  exp_len_q;
	logic             adv;

	assign adv = valid_s1 && (!valid_s2 || result_ch.ready);
	assign char_ch.ready = !valid_s1 || adv;

	b32d_step u_step (
		.state           (state_q),
		.char_code       (char_s1),
		.last_char       (last_s1),
		.expected_length (exp_len_q),
		.state_next      (state_next),
		.result          (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= '0;
		end else if (cfg_wr_en) begin
			exp_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ch.ready) begin
			valid_s1 <= char_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ch.ready && char_ch.valid) begin
			char_s1 <= char_ch.char_code;
			last_s1 <= char_ch.last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (adv) begin
				valid_s2 <= 1'b1;
				state_q  <= state_next;
			end else if (result_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_next;
		end
	end

	assign result_ch.valid       = valid_s2;
	assign result_ch.out_byte    = res_s2.out_byte;
	assign result_ch.byte_valid  = res_s2.byte_valid;
	assign result_ch.string_done = res_s2.string_done;
	assign result_ch.verdict     = res_s2.verdict;

`ifndef SYNTHESIS
	a_cont_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.string_done |-> res_s2.verdict == VERDICT_CONT)
		else $error("verdict set on a continuing item");

	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.byte_valid |-> res_s2.out_byte == '0)
		else $error("out_byte nonzero without byte_valid");

	a_clear_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> state_q == '0)
		else $error("string state not cleared after last item");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("input register lost a stalled item");

	a_no_byte_after_fail: assert property (@(posedge clk) disable iff (!arst_n)
		adv && state_q.failed |-> !res_next.byte_valid)
		else $error("byte released after a bad character");
`endif

endmodule

`default_nettype wire
